### sv/clkf_pkg.sv
// Shared types, codes and slot tables for the clock face fader.
`timescale 1ns / 1ps

package clkf_pkg;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_SET_MIN   = 3'd1,
    REQ_SET_HOUR  = 3'd2,
    REQ_HOURS_OFF = 3'd3,
    REQ_HOURS_ON  = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    MODE_RISE  = 3'd0,
    MODE_FADE  = 3'd1,
    MODE_TOP   = 3'd2,
    MODE_BLINK = 3'd3,
    MODE_HOLD  = 3'd4,
    MODE_OFF   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CFG_TOP_LEVEL   = 2'd0,
    CFG_RAMP_TICKS  = 2'd1,
    CFG_BLINK_TICKS = 2'd2
  } cfg_reg_t;

  localparam int unsigned MIN_SLOTS  = 24;
  localparam int unsigned HOUR_SLOTS = 12;

  // per-channel request, decoded once in the top level
  typedef struct packed {
    logic       tick;
    logic       start;
    logic [2:0] start_mode;
    logic       hours_off;
    logic       hours_on;
  } chan_cmd_t;

  // hour byte bits contributed by a minute slot
  function automatic logic [7:0] min_slot_hour_bits(input logic [4:0] slot);
    logic [7:0] b;
    b = 8'h00;
    if (slot == 5'd0) begin
      b = 8'h80;
    end else if (slot >= 5'd13) begin
      b = slot[0] ? 8'h40 : 8'h80;
    end
    return b;
  endfunction

  // minute byte bits contributed by a minute slot
  function automatic logic [7:0] min_slot_min_bits(input logic [4:0] slot);
    logic [7:0] b;
    case (slot)
      5'd0:  b = 8'h28;
      5'd1:  b = 8'h40;
      5'd2:  b = 8'h80;
      5'd3:  b = 8'h41;
      5'd4:  b = 8'h88;
      5'd5:  b = 8'h42;
      5'd6:  b = 8'h90;
      5'd7:  b = 8'h43;
      5'd8:  b = 8'h98;
      5'd9:  b = 8'h44;
      5'd10: b = 8'hA0;
      5'd11: b = 8'h45;
      5'd12: b = 8'hA8;
      5'd13: b = 8'h00;
      5'd14: b = 8'h00;
      5'd15: b = 8'h01;
      5'd16: b = 8'h08;
      5'd17: b = 8'h02;
      5'd18: b = 8'h10;
      5'd19: b = 8'h03;
      5'd20: b = 8'h18;
      5'd21: b = 8'h04;
      5'd22: b = 8'h20;
      5'd23: b = 8'h05;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // hour byte bits for an hour slot
  function automatic logic [7:0] hour_slot_bits(input logic [4:0] slot);
    logic [7:0] b;
    case (slot)
      5'd0:  b = 8'h28;
      5'd1:  b = 8'h00;
      5'd2:  b = 8'h00;
      5'd3:  b = 8'h01;
      5'd4:  b = 8'h08;
      5'd5:  b = 8'h02;
      5'd6:  b = 8'h10;
      5'd7:  b = 8'h03;
      5'd8:  b = 8'h18;
      5'd9:  b = 8'h04;
      5'd10: b = 8'h20;
      5'd11: b = 8'h05;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/clkf_channel.sv
// One PWM channel: mode, level, duty, tick timer and connection state.
`timescale 1ns / 1ps

module clkf_channel #(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  clkf_pkg::chan_cmd_t cmd,
  input  logic [7:0]          top_level,
  input  logic [15:0]         ramp_step_ticks,
  input  logic [15:0]         blink_ticks,
  output logic [7:0]          duty,
  output logic                connected
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  clkf_pkg::mode_t       mode, mode_next;
  logic [7:0]            level, level_next;
  logic [7:0]            duty_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic                  uses_blink, uses_blink_next;
  logic                  connected_next;

  logic [TIMER_BITS-1:0] timer_inc;
  logic [CW-1:0]         timer_ext;
  logic [CW-1:0]         delay_ext;
  logic                  elapsed;
  clkf_pkg::mode_t       new_mode;

  always_comb begin
    timer_inc = (timer == {TIMER_BITS{1'b1}}) ? timer : timer + 1'b1;
    timer_ext = CW'(timer_inc);
    delay_ext = CW'(uses_blink ? blink_ticks : ramp_step_ticks);
    elapsed   = (timer_ext >= delay_ext);
    // codes above off start as hold
    new_mode  = (cmd.start_mode > 3'(clkf_pkg::MODE_OFF)) ? clkf_pkg::MODE_HOLD
                                                         : clkf_pkg::mode_t'(cmd.start_mode);
  end

  always_comb begin
    mode_next       = mode;
    level_next      = level;
    duty_next       = duty;
    timer_next      = timer;
    uses_blink_next = uses_blink;
    connected_next  = connected;
    if (cmd.tick) begin
      timer_next = timer_inc;
      if (elapsed) begin
        timer_next = '0;
        case (mode)
          clkf_pkg::MODE_RISE: begin
            if (level >= top_level || level == 8'hFF) begin
              mode_next = clkf_pkg::MODE_HOLD;
              duty_next = level;
            end else begin
              level_next = level + 8'd1;
              duty_next  = level + 8'd1;
            end
          end
          clkf_pkg::MODE_FADE: begin
            if (level == 8'd0) begin
              mode_next      = clkf_pkg::MODE_HOLD;
              connected_next = 1'b0;
              duty_next      = 8'd0;
            end else begin
              level_next = level - 8'd1;
              duty_next  = level - 8'd1;
            end
          end
          clkf_pkg::MODE_BLINK: begin
            level_next = (level == top_level) ? 8'd0 : top_level;
            duty_next  = (level == top_level) ? 8'd0 : top_level;
          end
          default: begin
          end
        endcase
      end
    end else if (cmd.start) begin
      mode_next  = new_mode;
      timer_next = '0;
      case (new_mode)
        clkf_pkg::MODE_RISE: begin
          level_next      = 8'd0;
          duty_next       = 8'd0;
          uses_blink_next = 1'b0;
        end
        clkf_pkg::MODE_FADE: begin
          level_next      = top_level;
          duty_next       = top_level;
          uses_blink_next = 1'b0;
        end
        clkf_pkg::MODE_TOP: begin
          duty_next = top_level;
        end
        clkf_pkg::MODE_BLINK: begin
          level_next      = top_level;
          duty_next       = top_level;
          uses_blink_next = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.hours_off) begin
      mode_next      = clkf_pkg::MODE_OFF;
      duty_next      = 8'd0;
      connected_next = 1'b0;
    end else if (cmd.hours_on) begin
      if (mode != clkf_pkg::MODE_HOLD && mode != clkf_pkg::MODE_OFF) begin
        connected_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= clkf_pkg::MODE_OFF;
      level      <= 8'd0;
      duty       <= 8'd0;
      timer      <= '0;
      uses_blink <= 1'b0;
      connected  <= 1'b1;
    end else if (step) begin
      mode       <= mode_next;
      level      <= level_next;
      duty       <= duty_next;
      timer      <= timer_next;
      uses_blink <= uses_blink_next;
      connected  <= connected_next;
    end
  end

endmodule

### sv/led_clock_face_fader.sv
// Top level of the LED clock face fader: request decode, select bytes, channels.
`timescale 1ns / 1ps

// Channel     | Dir | Handshake                     | Payload
// s_axis      | in  | s_axis_tvalid / s_axis_tready | request beat: type, slot, light mode
// m_axis      | out | m_axis_tvalid / m_axis_tready | result beat: select bytes, duties, enables
// cfg         | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data (register write)
//
// Every request beat produces exactly one result beat, valid the cycle after accept.
// Channels and select bytes update in the accept cycle and the state registers
// serve as the result register: one beat per cycle while m_axis_tready is high.
// A result waiting on m_axis holds off s_axis (tready follows the output side).
// Synchronous reset restores config defaults, clears the bytes, and sets all
// channels to off with duty zero and outputs connected.

module led_clock_face_fader #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] req_type, [7:3] slot, [10:8] light_mode, [15:11] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] minute_select, [15:8] hour_select, [23:16] duty_min_odd,
  // [31:24] duty_min_even, [39:32] duty_hour_odd, [47:40] duty_hour_even,
  // [51:48] output_enables, [55:52] zero
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NUM_CH = 4;

  // config registers
  logic [7:0]  top_level;
  logic [15:0] ramp_step_ticks;
  logic [15:0] blink_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_level       <= 8'd255;
      ramp_step_ticks <= 16'd10;
      blink_ticks     <= 16'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clkf_pkg::CFG_TOP_LEVEL:   top_level       <= cfg_data[7:0];
        clkf_pkg::CFG_RAMP_TICKS:  ramp_step_ticks <= cfg_data;
        clkf_pkg::CFG_BLINK_TICKS: blink_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request fields
  logic       in_beat;
  logic [2:0] req_type;
  logic [4:0] slot;
  logic [2:0] light_mode;
  logic       min_ok;
  logic       hour_ok;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign req_type      = s_axis_tdata[2:0];
  assign slot          = s_axis_tdata[7:3];
  assign light_mode    = s_axis_tdata[10:8];

  assign min_ok  = (req_type == clkf_pkg::REQ_SET_MIN) && (slot < 5'(clkf_pkg::MIN_SLOTS));
  assign hour_ok = (req_type == clkf_pkg::REQ_SET_HOUR) && (slot < 5'(clkf_pkg::HOUR_SLOTS));

  // channel commands: 0 min odd, 1 min even, 2 hour odd, 3 hour even
  clkf_pkg::chan_cmd_t cmd [NUM_CH];
  logic [7:0]          duty [NUM_CH];
  logic [NUM_CH-1:0]   connected;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      cmd[i].tick       = (req_type == clkf_pkg::REQ_TICK);
      cmd[i].start_mode = light_mode;
      cmd[i].hours_off  = (i >= 2) && (req_type == clkf_pkg::REQ_HOURS_OFF);
      cmd[i].hours_on   = (i >= 2) && (req_type == clkf_pkg::REQ_HOURS_ON);
    end
    cmd[0].start = min_ok && slot[0];
    cmd[1].start = min_ok && !slot[0];
    cmd[2].start = hour_ok && slot[0];
    cmd[3].start = hour_ok && !slot[0];
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    clkf_channel #(
      .TIMER_BITS(TIMER_BITS)
    ) u_ch (
      .clk            (clk),
      .rst            (rst),
      .step           (in_beat),
      .cmd            (cmd[g]),
      .top_level      (top_level),
      .ramp_step_ticks(ramp_step_ticks),
      .blink_ticks    (blink_ticks),
      .duty           (duty[g]),
      .connected      (connected[g])
    );
  end

  // select bytes accumulate by OR until cleared
  logic [7:0] minute_byte, minute_byte_next;
  logic [7:0] hour_byte, hour_byte_next;

  always_comb begin
    minute_byte_next = minute_byte;
    hour_byte_next   = hour_byte;
    case (req_type)
      clkf_pkg::REQ_SET_MIN: begin
        if (min_ok) begin
          hour_byte_next   = hour_byte | clkf_pkg::min_slot_hour_bits(slot);
          minute_byte_next = minute_byte | clkf_pkg::min_slot_min_bits(slot);
        end
      end
      clkf_pkg::REQ_SET_HOUR: begin
        if (hour_ok) begin
          hour_byte_next = hour_byte | clkf_pkg::hour_slot_bits(slot);
        end
      end
      clkf_pkg::REQ_CLEAR: begin
        minute_byte_next = 8'd0;
        hour_byte_next   = 8'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_byte   <= 8'd0;
      hour_byte     <= 8'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_beat) begin
        minute_byte <= minute_byte_next;
        hour_byte   <= hour_byte_next;
      end
      if (in_beat) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {4'd0, connected, duty[3], duty[2], duty[1], duty[0],
                         hour_byte, minute_byte};

  // result beat only changes when a request is taken
  a_stable_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_beat |=> $stable(m_axis_tdata))
    else $error("result changed without a request beat");

  // hours off silences and disconnects both hour channels
  a_hours_off: assert property (@(posedge clk) disable iff (rst)
    (in_beat && req_type == clkf_pkg::REQ_HOURS_OFF) |=>
      (m_axis_tdata[51:50] == 2'b00 && m_axis_tdata[47:32] == 16'd0))
    else $error("hours off left an hour channel active");

  // clear empties both select bytes
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_beat && req_type == clkf_pkg::REQ_CLEAR) |=> (m_axis_tdata[15:0] == 16'd0))
    else $error("clear did not empty select bytes");

  // every accepted request shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> m_axis_tvalid)
    else $error("request beat without result beat");

endmodule
